// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the timestamp table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== sv/stt_pkg.sv =====
// Types and codes of the sorted timestamp table
package stt_pkg;

  localparam int CMD_W    = 2;
  localparam int STAMP_W  = 32;
  localparam int KIND_W   = 8;
  localparam int STATUS_W = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MATCH     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd5;

  // One stored table entry
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [KIND_W-1:0]  kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/stt_if.sv =====
// Valid/ready channel interfaces for commands and results of the timestamp table
interface stt_in_if;
  logic                          valid;
  logic                          ready;
  logic [stt_pkg::CMD_W-1:0]     command;
  logic [stt_pkg::STAMP_W-1:0]   stamp;
  logic [stt_pkg::KIND_W-1:0]    kind_code;
  logic [stt_pkg::STAMP_W-1:0]   range_low;
  logic [stt_pkg::STAMP_W-1:0]   range_high;

  modport source (output valid, command, stamp, kind_code, range_low, range_high,
                  input ready);
  modport sink (input valid, command, stamp, kind_code, range_low, range_high,
                output ready);
endinterface

interface stt_out_if;
  logic                          valid;
  logic                          ready;
  logic [stt_pkg::STATUS_W-1:0]  status;
  logic [stt_pkg::STAMP_W-1:0]   entry_stamp;
  logic [stt_pkg::KIND_W-1:0]    entry_kind;
  logic                          last;

  modport source (output valid, status, entry_stamp, entry_kind, last, input ready);
  modport sink (input valid, status, entry_stamp, entry_kind, last, output ready);
endinterface

// ===== sv/stt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port
module stt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sorted_timestamp_table.sv =====
// Top level of the sorted timestamp table: sequencer, entry count and result register
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------------------------
//  in_chan   | in  | valid/ready   | command, stamp, kind_code, range_low, range_high
//  out_chan  | out | valid/ready   | status, entry_stamp, entry_kind, last
//
//  Insert walks down from the tail to its insert position; remove and query scan every
//  stored entry, one RAM read per cycle unless a stalled out_chan holds the query scan.
//  One command is worked at a time; in_chan.ready is high only between commands.
//  Reset clears the entry count; RAM contents stay undefined and need no clearing.
//  A stalled out_chan holds the query scan (the entry is read again) until the
//  result register frees up.
`include "assert_macros.svh"

module sorted_timestamp_table #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  stt_in_if.sink     in_chan,
  stt_out_if.source  out_chan
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_QRY   = 3'd4;
  localparam logic [2:0] S_QEND  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  // Control state
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers
  logic [stt_pkg::STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [stt_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [stt_pkg::STAMP_W-1:0]  lo_r, lo_nxt;
  logic [stt_pkg::STAMP_W-1:0]  hi_r, hi_nxt;
  logic [stt_pkg::STATUS_W-1:0] resp_r, resp_nxt;
  stt_pkg::entry_t              pend_r, pend_nxt;
  logic [stt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [stt_pkg::STAMP_W-1:0]  out_stamp_r, out_stamp_nxt;
  logic [stt_pkg::KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic                         out_last_r, out_last_nxt;

  // RAM access
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  stt_pkg::entry_t             mem_wdata;
  logic [stt_pkg::ENTRY_W-1:0] mem_rdata_raw;
  stt_pkg::entry_t             mem_rd;
  stt_pkg::entry_t             new_entry;

  logic          out_free;
  logic [CW-1:0] count_m1;
  logic          at_end;
  logic          hit_eq;
  logic          hit_rng;

  stt_ram #(
    .WIDTH (stt_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  assign mem_rd    = stt_pkg::entry_t'(mem_rdata_raw);
  assign new_entry = '{stamp: stamp_r, kind: kind_r};
  assign out_free  = !out_valid_r || out_chan.ready;
  assign count_m1  = count_r - CW'(1);
  assign at_end    = (CW'(idx_r) == count_m1);
  assign hit_eq    = (mem_rd.stamp == stamp_r);
  assign hit_rng   = (mem_rd.stamp >= lo_r) && (mem_rd.stamp <= hi_r);

  // Sequence commands over the RAM
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    stamp_nxt      = stamp_r;
    kind_nxt       = kind_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_stamp_nxt  = out_stamp_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = new_entry;
    mem_raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          stamp_nxt = in_chan.stamp;
          kind_nxt  = in_chan.kind_code;
          lo_nxt    = in_chan.range_low;
          hi_nxt    = in_chan.range_high;
          case (in_chan.command)
            stt_pkg::CMD_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                resp_nxt  = stt_pkg::ST_FULL;
                state_nxt = S_RESP;
              end else if (count_r == '0) begin
                idx_nxt   = '0;
                state_nxt = S_PLACE;
              end else begin
                // walk down from the tail, first read the last entry
                idx_nxt   = count_r[AW-1:0];
                mem_raddr = count_m1[AW-1:0];
                state_nxt = S_INS;
              end
            end
            stt_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                resp_nxt  = stt_pkg::ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                idx_nxt   = '0;
                mem_raddr = '0;
                found_nxt = 1'b0;
                state_nxt = S_REM;
              end
            end
            stt_pkg::CMD_QUERY: begin
              if (count_r == '0) begin
                resp_nxt  = stt_pkg::ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                idx_nxt    = '0;
                mem_raddr  = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_QRY;
              end
            end
            default: begin
              // unused command: drop it without a result
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INS: begin
        // read data is entry idx_r - 1
        if (mem_rd.stamp > stamp_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = mem_rd;
          idx_nxt   = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            mem_raddr = idx_r - AW'(2);
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = new_entry;
          count_nxt = count_r + CW'(1);
          resp_nxt  = stt_pkg::ST_DONE;
          state_nxt = S_RESP;
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = new_entry;
        count_nxt = count_r + CW'(1);
        resp_nxt  = stt_pkg::ST_DONE;
        state_nxt = S_RESP;
      end

      S_REM: begin
        // read data is entry idx_r; past the hit, move each entry down one
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r - AW'(1);
          mem_wdata = mem_rd;
        end
        found_nxt = found_r || hit_eq;
        if (at_end) begin
          if (found_r || hit_eq) begin
            count_nxt = count_m1;
            resp_nxt  = stt_pkg::ST_DONE;
          end else begin
            resp_nxt  = stt_pkg::ST_NOT_FOUND;
          end
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          mem_raddr = idx_r + AW'(1);
        end
      end

      S_QRY: begin
        // hold one match back so the final one can carry last
        if (hit_rng && pend_v_r && !out_free) begin
          mem_raddr = idx_r;
        end else begin
          if (hit_rng) begin
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = stt_pkg::ST_MATCH;
              out_stamp_nxt  = pend_r.stamp;
              out_kind_nxt   = pend_r.kind;
              out_last_nxt   = 1'b0;
            end
            pend_nxt   = mem_rd;
            pend_v_nxt = 1'b1;
          end
          if (at_end) begin
            state_nxt = S_QEND;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            mem_raddr = idx_r + AW'(1);
          end
        end
      end

      S_QEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (pend_v_r) begin
            out_status_nxt = stt_pkg::ST_MATCH;
            out_stamp_nxt  = pend_r.stamp;
            out_kind_nxt   = pend_r.kind;
          end else begin
            out_status_nxt = stt_pkg::ST_NO_MATCH;
            out_stamp_nxt  = '0;
            out_kind_nxt   = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_stamp_nxt  = '0;
          out_kind_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    stamp_r      <= stamp_nxt;
    kind_r       <= kind_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    resp_r       <= resp_nxt;
    pend_r       <= pend_nxt;
    out_status_r <= out_status_nxt;
    out_stamp_r  <= out_stamp_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_stamp = out_stamp_r;
  assign out_chan.entry_kind  = out_kind_r;
  assign out_chan.last        = out_last_r;

  // Checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH),
    "entry count above table depth")
  `ASSERT_IMPL(a_write_state, clk, rst_n, mem_we,
    state_r == S_INS || state_r == S_PLACE || state_r == S_REM,
    "RAM write outside insert or remove")
  `ASSERT_NEXT(a_final_last, clk, rst_n,
    (state_r == S_RESP || state_r == S_QEND) && out_free,
    out_valid_r && out_last_r, "closing item lacks last")

endmodule

// ===== tb/sorted_timestamp_table_tb.sv =====
// Testbench for the sorted timestamp table: directed, fill, backpressure and random tests
module sorted_timestamp_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic [stt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [stt_pkg::STAMP_W-1:0] STAMP_MAX = '1;
  localparam int TAIL_CYCLES = 2 * DEPTH + 20;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [stt_pkg::STATUS_W-1:0] status;
    logic [stt_pkg::STAMP_W-1:0]  entry_stamp;
    logic [stt_pkg::KIND_W-1:0]   entry_kind;
    logic                         last;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n;

  stt_in_if  in_if ();
  stt_out_if out_if ();

  sorted_timestamp_table #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow copy of the table contents
  logic [stt_pkg::STAMP_W-1:0] shadow_stamp [DEPTH];
  logic [stt_pkg::KIND_W-1:0]  shadow_kind  [DEPTH];
  int                          shadow_count;

  table_result_t expected_results [$];
  int            err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_len;
  bit            holding = 1'b0;
  event          hold_off_ev;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Abort a hung run
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Work out the results of one accepted command and update the shadow table
  function automatic void apply_command(logic [stt_pkg::CMD_W-1:0]   cmd,
                                        logic [stt_pkg::STAMP_W-1:0] stamp,
                                        logic [stt_pkg::KIND_W-1:0]  kind,
                                        logic [stt_pkg::STAMP_W-1:0] lo,
                                        logic [stt_pkg::STAMP_W-1:0] hi);
    table_result_t res [$];
    table_result_t one;
    int pos;
    pos = shadow_count;
    one = '0;
    case (cmd)
      stt_pkg::CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          one.status = stt_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_stamp[i] > stamp) begin
              pos = i;
              break;
            end
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_stamp[i] = shadow_stamp[i-1];
            shadow_kind[i]  = shadow_kind[i-1];
          end
          shadow_stamp[pos] = stamp;
          shadow_kind[pos]  = kind;
          shadow_count++;
          one.status = stt_pkg::ST_DONE;
        end
        res = {res, one};
      end
      stt_pkg::CMD_REMOVE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_stamp[i] == stamp) begin
            pos = i;
            break;
          end
        end
        if (pos == shadow_count) begin
          one.status = stt_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_stamp[i] = shadow_stamp[i+1];
            shadow_kind[i]  = shadow_kind[i+1];
          end
          shadow_count--;
          one.status = stt_pkg::ST_DONE;
        end
        res = {res, one};
      end
      stt_pkg::CMD_QUERY: begin
        if (shadow_count == 0) begin
          one.status = stt_pkg::ST_EMPTY;
          res = {res, one};
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_stamp[i] >= lo && shadow_stamp[i] <= hi) begin
              one.status      = stt_pkg::ST_MATCH;
              one.entry_stamp = shadow_stamp[i];
              one.entry_kind  = shadow_kind[i];
              res = {res, one};
            end
          end
          if (res.size() == 0) begin
            one.status = stt_pkg::ST_NO_MATCH;
            res = {res, one};
          end
        end
      end
      default: ;
    endcase
    if (res.size() != 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_results = {expected_results, res[i]};
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d stamp %0h kind %0h last %0b",
               out_if.status, out_if.entry_stamp, out_if.entry_kind, out_if.last);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          err_cnt++;
        end
        if (out_if.entry_stamp !== want.entry_stamp) begin
          $error("entry_stamp: expected %0h, got %0h", want.entry_stamp, out_if.entry_stamp);
          err_cnt++;
        end
        if (out_if.entry_kind !== want.entry_kind) begin
          $error("entry_kind: expected %0h, got %0h", want.entry_kind, out_if.entry_kind);
          err_cnt++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          err_cnt++;
        end
      end
    end
  end

  // Drive result ready: random stalls, or held low during a hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holding) out_if.ready <= 1'b0;
      else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count out a long receiver hold-off
  always begin
    @(hold_off_ev);
    holding = 1'b1;
    repeat (hold_len) @(posedge clk);
    holding = 1'b0;
  end

  // Offer one command and hold it until accepted
  task automatic send_cmd(logic [stt_pkg::CMD_W-1:0]   cmd,
                          logic [stt_pkg::STAMP_W-1:0] stamp,
                          logic [stt_pkg::KIND_W-1:0]  kind,
                          logic [stt_pkg::STAMP_W-1:0] lo,
                          logic [stt_pkg::STAMP_W-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.stamp      <= stamp;
    in_if.kind_code  <= kind;
    in_if.range_low  <= lo;
    in_if.range_high <= hi;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    apply_command(cmd, stamp, kind, lo, hi);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Random kind code
  function automatic logic [stt_pkg::KIND_W-1:0] rand_kind();
    int unsigned r;
    r = $urandom;
    return r[stt_pkg::KIND_W-1:0];
  endfunction

  function automatic logic [stt_pkg::STAMP_W-1:0] fresh_stamp();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return $urandom_range(300, 0);
      12, 13, 14: return STAMP_MAX - $urandom_range(3, 0);
      15: return $urandom_range(3, 0);
      default: return $urandom;
    endcase
  endfunction

  // Stamp of an entry now in the table, or a fresh one if it is empty
  function automatic logic [stt_pkg::STAMP_W-1:0] held_stamp();
    if (shadow_count == 0) return fresh_stamp();
    return shadow_stamp[$urandom_range(shadow_count - 1, 0)];
  endfunction

  task automatic send_random_command();
    logic [stt_pkg::CMD_W-1:0]   cmd;
    logic [stt_pkg::STAMP_W-1:0] stamp, lo, hi, tmp;
    int ins_pct, r;
    ins_pct = (shadow_count < 8) ? 70 : (shadow_count > 56) ? 20 : 40;
    r = $urandom_range(99);
    if ($urandom_range(99) < 3) cmd = CMD_UNUSED;
    else if (r < ins_pct) cmd = stt_pkg::CMD_INSERT;
    else if (r < ins_pct + 30) cmd = stt_pkg::CMD_REMOVE;
    else cmd = stt_pkg::CMD_QUERY;
    stamp = (cmd == stt_pkg::CMD_REMOVE && $urandom_range(3) != 0) ? held_stamp()
                                                                    : fresh_stamp();
    lo = $urandom;
    hi = $urandom;
    if (cmd == stt_pkg::CMD_QUERY) begin
      case ($urandom_range(4))
        0, 1: begin
          lo = held_stamp();
          hi = held_stamp();
          if (lo > hi && $urandom_range(3) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
        2: begin
          lo = '0;
          hi = STAMP_MAX;
        end
        3: begin
          lo = $urandom_range(300, 0);
          hi = lo + $urandom_range(80, 0);
        end
        default: ;
      endcase
    end
    send_cmd(cmd, stamp, rand_kind(), lo, hi);
  endtask

  // Extremes, equal stamps, every status but full and the unused command
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, '0, STAMP_MAX);
    send_cmd(stt_pkg::CMD_REMOVE, '0, '0, '0, '0);
    send_cmd(CMD_UNUSED, STAMP_MAX, 8'hFF, STAMP_MAX, STAMP_MAX);
    send_cmd(stt_pkg::CMD_INSERT, STAMP_MAX, 8'hFF, '0, '0);
    send_cmd(stt_pkg::CMD_INSERT, '0, 8'h00, '0, '0);
    send_cmd(stt_pkg::CMD_INSERT, 32'd100, 8'hA5, '0, '0);
    send_cmd(stt_pkg::CMD_INSERT, 32'd100, 8'h5A, '0, '0);
    send_cmd(stt_pkg::CMD_INSERT, 32'd100, 8'h01, '0, '0);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, '0, STAMP_MAX);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, 32'd100, 32'd100);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, 32'd200, 32'd100);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, 32'd101, 32'd1000);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, STAMP_MAX, STAMP_MAX);
    send_cmd(stt_pkg::CMD_REMOVE, 32'd100, '0, '0, '0);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, '0, STAMP_MAX);
    send_cmd(stt_pkg::CMD_REMOVE, 32'd55, '0, '0, '0);
    send_cmd(stt_pkg::CMD_REMOVE, STAMP_MAX, '0, '0, '0);
    send_cmd(stt_pkg::CMD_REMOVE, '0, '0, '0, '0);
    send_cmd(CMD_UNUSED, '0, '0, '0, '0);
    send_cmd(stt_pkg::CMD_REMOVE, 32'd100, '0, '0, '0);
    send_cmd(stt_pkg::CMD_REMOVE, 32'd100, '0, '0, '0);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, '0, STAMP_MAX);
    wait_all_results();
  endtask

  // Fill the table, overflow it, read it whole, then empty it
  task automatic test_fill_to_full();
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    while (shadow_count < DEPTH) begin
      send_cmd(stt_pkg::CMD_INSERT, fresh_stamp(), rand_kind(), $urandom, $urandom);
    end
    repeat (3) send_cmd(stt_pkg::CMD_INSERT, fresh_stamp(), rand_kind(), '0, '0);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, '0, STAMP_MAX);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, 32'd50, 32'd150);
    while (shadow_count > 0) begin
      send_cmd(stt_pkg::CMD_REMOVE, held_stamp(), '0, $urandom, $urandom);
    end
    wait_all_results();
  endtask

  // Hold off the receiver long enough that the block stalls its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (40) send_cmd(stt_pkg::CMD_INSERT, fresh_stamp(), rand_kind(), '0, '0);
    hold_len = 400;
    -> hold_off_ev;
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, '0, STAMP_MAX);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, '0, STAMP_MAX);
    send_cmd(stt_pkg::CMD_INSERT, fresh_stamp(), rand_kind(), '0, '0);
    send_cmd(stt_pkg::CMD_REMOVE, held_stamp(), '0, '0, '0);
    send_cmd(stt_pkg::CMD_QUERY, '0, '0, 32'd0, 32'd300);
    send_cmd(stt_pkg::CMD_INSERT, fresh_stamp(), rand_kind(), '0, '0);
    wait_all_results();
  endtask

  task automatic test_random_mix(int n_items, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_random_command();
    wait_all_results();
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    shadow_count   = 0;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= stt_pkg::CMD_INSERT;
    in_if.stamp      <= '0;
    in_if.kind_code  <= '0;
    in_if.range_low  <= '0;
    in_if.range_high <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_to_full();
    test_backpressure();
    test_random_mix(70, 0, 0);
    test_random_mix(70, 70, 0);
    test_random_mix(70, 0, 70);
    test_random_mix(70, 9, 9);

    // Let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never came", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/stt_pkg.sv
sv/stt_if.sv
sv/stt_ram.sv
sv/sorted_timestamp_table.sv
tb/sorted_timestamp_table_tb.sv
